/* sv/ptfc_pkg.sv */
// Shared constants, types and the texel packing function of the palette texel converter.
package ptfc_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int RGB_W         = 24;
   localparam int TEXEL_W       = 16;
   localparam int INDEX_W       = 8;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 24;

   localparam logic [TEXEL_W-1:0] ALPHA_HI = 16'h8000;
   localparam logic [TEXEL_W-1:0] ALPHA_LO = 16'h0001;
   localparam logic [TEXEL_W-1:0] ALPHA_NONE = 16'h0000;

   typedef enum logic [2:0] {
      FMT_RGB565   = 3'd0,
      FMT_BGR565   = 3'd1,
      FMT_RGB555   = 3'd2,
      FMT_RGBA5551 = 3'd3,
      FMT_ARGB1555 = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      FUNC_PAL_WRITE = 2'd0,
      FUNC_INDEXED   = 2'd1,
      FUNC_DIRECT    = 2'd2
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_BACKGROUND   = 2'd1,
      CSR_DOUBLE_WIDTH = 2'd2
   } csr_index_type;

   function automatic logic [TEXEL_W-1:0] pack_texel(
      input logic [RGB_W-1:0] rgb,
      input logic [2:0]       fmt,
      input logic             alpha_set
   );
      logic [4:0] r5;
      logic [4:0] g5;
      logic [4:0] b5;
      logic [5:0] g6;
      logic [TEXEL_W-1:0] t;
      r5 = rgb[23:19];
      g5 = rgb[15:11];
      g6 = rgb[15:10];
      b5 = rgb[7:3];
      case (fmt)
         FMT_BGR565: begin
            t = {b5, g6, r5};
         end
         FMT_RGB555: begin
            t = {1'b0, r5, g5, b5};
         end
         FMT_RGBA5551: begin
            t = {r5, g5, b5, 1'b0} | (alpha_set ? ALPHA_LO : ALPHA_NONE);
         end
         FMT_ARGB1555: begin
            t = {1'b0, r5, g5, b5} | (alpha_set ? ALPHA_HI : ALPHA_NONE);
         end
         default: begin
            t = {r5, g6, b5};
         end
      endcase
      return t;
   endfunction

endpackage

/* sv/ptfc_palette_ram.sv */
// Palette memory with one write port and one registered read port.
module ptfc_palette_ram
   import ptfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PAL_ADDR_W-1:0] wr_addr,
   input  logic [RGB_W-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [PAL_ADDR_W-1:0] rd_addr,
   output logic [RGB_W-1:0]      rd_data
);

   logic [RGB_W-1:0] mem [PALETTE_DEPTH];
   logic [RGB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/palette_texel_format_converter_top.sv */
// Top level of the palette texel converter: palette memory, lookup stage and output register.
// An indexed or direct item is registered in the lookup stage, then in the output register;
// either can be held by back-pressure. Throughput: one item per cycle while rsp_ready is high;
// with width doubling on, an indexed item holds the output register until both copies are
// taken. The rate is set by the single read port of the palette memory and output register.
// Reset clears pipeline valids and CSR registers; palette contents are kept as they are.
module palette_texel_format_converter_top
   import ptfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [INDEX_W-1:0]     req_pixel_index,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   input  logic [TEXEL_W-1:0]     req_direct_texel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TEXEL_W-1:0]     rsp_texel,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [2:0]         pixel_format_ff;
   logic [RGB_W-1:0]   background_ff;
   logic               double_width_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_direct_ff;
   logic               s1_idx_zero_ff;
   logic               s1_in_range_ff;
   logic [TEXEL_W-1:0] s1_texel_ff;

   logic               out_valid_ff, out_valid_in;
   logic [TEXEL_W-1:0] out_texel_ff;
   logic               out_last_ff;

   logic               req_fire;
   logic               in_range;
   logic               out_free;
   logic               s1_adv;
   logic               bg_pick;
   logic [RGB_W-1:0]   rd_data;
   logic [RGB_W-1:0]   colour;
   logic [TEXEL_W-1:0] s1_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RGB565;
         background_ff   <= '0;
         double_width_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[2:0];
            CSR_BACKGROUND:   background_ff   <= csr_wdata[RGB_W-1:0];
            CSR_DOUBLE_WIDTH: double_width_ff <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   assign in_range = ({1'b0, req_pixel_index} < 9'(PALETTE_DEPTH));
   assign out_free = !out_valid_ff || (rsp_ready && out_last_ff);
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire = req_valid && req_ready;

   ptfc_palette_ram u_palette (
      .clock   (clock),
      .wr_en   (req_fire && (req_func == FUNC_PAL_WRITE) && in_range),
      .wr_addr (req_pixel_index[PAL_ADDR_W-1:0]),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (req_fire && (req_func == FUNC_INDEXED)),
      .rd_addr (req_pixel_index[PAL_ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_adv;
      if (req_fire) begin
         s1_valid_in = (req_func == FUNC_INDEXED) || (req_func == FUNC_DIRECT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_direct_ff   <= (req_func == FUNC_DIRECT);
         s1_idx_zero_ff <= (req_pixel_index == '0);
         s1_in_range_ff <= in_range;
         s1_texel_ff    <= req_direct_texel;
      end
   end

   always_comb begin
      bg_pick = s1_idx_zero_ff && ((pixel_format_ff == FMT_RGBA5551) ||
                                   (pixel_format_ff == FMT_ARGB1555));
      if (bg_pick) begin
         colour = background_ff;
      end else if (s1_in_range_ff) begin
         colour = rd_data;
      end else begin
         colour = '0;
      end
      s1_result = s1_direct_ff ? s1_texel_ff : pack_texel(colour, pixel_format_ff, !bg_pick);
   end

   always_comb begin
      out_valid_in = out_valid_ff && !(rsp_ready && out_last_ff);
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_texel_ff <= s1_result;
         out_last_ff  <= s1_direct_ff || !double_width_ff;
      end else if (out_valid_ff && rsp_ready && !out_last_ff) begin
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_texel       = out_texel_ff;
   assign rsp_last_of_run = out_last_ff;

`ifndef NO_ASSERTIONS
   a_second_copy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=>
         (rsp_valid && rsp_last_of_run && $stable(rsp_texel)))
      else $error("Doubled texel did not repeat as the final result.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_ready)
      else $error("Item accepted while the lookup stage was blocked.");

   a_double_only_when_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> double_width_ff)
      else $error("Non-final result seen with width doubling off.");
`endif

endmodule

/* dv/palette_texel_format_converter_top_tb.sv */
// Self-checking testbench for the palette texel converter: palette loads, indexed and direct items, doubling.
module palette_texel_format_converter_top_tb;
   import ptfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          IDLE_PERCENT  = 10;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          PRINT_LIMIT   = 40;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_ITEMS   = 180;
   localparam int          BURST_ITEMS   = 240;
   localparam logic [2:0]  FMT_UNUSED    = 3'd7;

   typedef struct {
      logic [1:0]         func;
      logic [INDEX_W-1:0] pixel_index;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [TEXEL_W-1:0] direct_texel;
   } pixel_req_type;

   typedef struct {
      logic [TEXEL_W-1:0] texel;
      logic               last_of_run;
   } texel_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_func = FUNC_PAL_WRITE;
   logic [INDEX_W-1:0]     req_pixel_index = '0;
   logic [7:0]             req_red = '0;
   logic [7:0]             req_green = '0;
   logic [7:0]             req_blue = '0;
   logic [TEXEL_W-1:0]     req_direct_texel = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TEXEL_W-1:0]     rsp_texel;
   logic                   rsp_last_of_run;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PIXEL_FORMAT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [RGB_W-1:0]       palette_copy [PALETTE_DEPTH];
   bit                     entry_loaded [PALETTE_DEPTH];
   int                     loaded_indices [$];
   texel_result_type       expected_texels [$];
   logic [2:0]             cur_format = FMT_RGB565;
   logic [RGB_W-1:0]       cur_background = '0;
   logic                   cur_double = 1'b0;
   bit                     no_gaps = 1'b0;
   int                     error_count = 0;
   int                     cycle_count = 0;

   palette_texel_format_converter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_pixel_index  (req_pixel_index),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_direct_texel (req_direct_texel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_texel        (rsp_texel),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      texel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_texels.size() == 0) begin
            report_mismatch("unexpected item, texel", rsp_texel, '0);
         end else begin
            want = expected_texels.pop_front();
            if (rsp_texel !== want.texel) begin
               report_mismatch("texel", rsp_texel, want.texel);
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               report_mismatch("last_of_run", {15'd0, rsp_last_of_run},
                               {15'd0, want.last_of_run});
            end
         end
      end
   end

   function automatic logic [15:0] pack_colour(input logic [RGB_W-1:0] rgb,
                                               input logic [2:0] fmt, input logic alpha);
      logic [15:0] r5;
      logic [15:0] g5;
      logic [15:0] g6;
      logic [15:0] b5;
      logic [15:0] word;
      r5 = 16'(rgb[23:19]);
      g5 = 16'(rgb[15:11]);
      g6 = 16'(rgb[15:10]);
      b5 = 16'(rgb[7:3]);
      case (fmt)
         FMT_BGR565: begin
            word = (b5 << 11) | (g6 << 5) | r5;
         end
         FMT_RGB555: begin
            word = (r5 << 10) | (g5 << 5) | b5;
         end
         FMT_RGBA5551: begin
            word = (r5 << 11) | (g5 << 6) | (b5 << 1) | {15'd0, alpha};
         end
         FMT_ARGB1555: begin
            word = (r5 << 10) | (g5 << 5) | b5 | {alpha, 15'd0};
         end
         default: begin
            word = (r5 << 11) | (g6 << 5) | b5;
         end
      endcase
      return word;
   endfunction

   task automatic predict_item(input pixel_req_type item);
      texel_result_type res;
      logic             alpha_fmt;
      case (item.func)
         FUNC_PAL_WRITE: begin
            palette_copy[item.pixel_index] = {item.red, item.green, item.blue};
            if (!entry_loaded[item.pixel_index]) begin
               entry_loaded[item.pixel_index] = 1'b1;
               loaded_indices.push_back(item.pixel_index);
            end
         end
         FUNC_DIRECT: begin
            res.texel = item.direct_texel;
            res.last_of_run = 1'b1;
            expected_texels.push_back(res);
         end
         FUNC_INDEXED: begin
            alpha_fmt = (cur_format == FMT_RGBA5551) || (cur_format == FMT_ARGB1555);
            if (alpha_fmt && item.pixel_index == 0) begin
               res.texel = pack_colour(cur_background, cur_format, 1'b0);
            end else begin
               res.texel = pack_colour(palette_copy[item.pixel_index], cur_format, 1'b1);
            end
            if (cur_double) begin
               res.last_of_run = 1'b0;
               expected_texels.push_back(res);
            end
            res.last_of_run = 1'b1;
            expected_texels.push_back(res);
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_item(input pixel_req_type item);
      if (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= item.func;
      req_pixel_index  <= item.pixel_index;
      req_red          <= item.red;
      req_green        <= item.green;
      req_blue         <= item.blue;
      req_direct_texel <= item.direct_texel;
      do @(posedge clock); while (!req_ready);
      predict_item(item);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_texels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PIXEL_FORMAT: begin
            cur_format = data[2:0];
         end
         CSR_BACKGROUND: begin
            cur_background = data;
         end
         CSR_DOUBLE_WIDTH: begin
            cur_double = data[0];
         end
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [2:0] fmt, input logic [RGB_W-1:0] bg,
                           input logic dbl);
      wait_for_results();
      repeat (4) @(posedge clock);
      write_csr(CSR_PIXEL_FORMAT, {21'd0, fmt});
      write_csr(CSR_BACKGROUND, bg);
      write_csr(CSR_DOUBLE_WIDTH, {23'd0, dbl});
   endtask

   function automatic pixel_req_type make_item(input logic [1:0] func, input int idx,
                                               input logic [RGB_W-1:0] rgb,
                                               input logic [TEXEL_W-1:0] direct);
      pixel_req_type item;
      item.func         = func;
      item.pixel_index  = idx[INDEX_W-1:0];
      item.red          = rgb[23:16];
      item.green        = rgb[15:8];
      item.blue         = rgb[7:0];
      item.direct_texel = direct;
      return item;
   endfunction

   function automatic pixel_req_type random_item();
      pixel_req_type item;
      int            pick;
      item = make_item(FUNC_PAL_WRITE, $urandom_range(255), 24'($urandom_range(24'hFFFFFF)),
                       16'($urandom_range(16'hFFFF)));
      pick = $urandom_range(99);
      if (pick >= 97) begin
         item.func = 2'd3;
      end else if (pick >= 80) begin
         item.func = FUNC_DIRECT;
      end else if (pick >= 22) begin
         item.func = FUNC_INDEXED;
         if ($urandom_range(9) == 0) begin
            item.pixel_index = '0;
         end else begin
            item.pixel_index =
               INDEX_W'(loaded_indices[$urandom_range(loaded_indices.size() - 1)]);
         end
      end
      return item;
   endfunction

   task automatic test_palette_load_and_direct();
      send_item(make_item(FUNC_PAL_WRITE, 0, 24'h000000, 16'h0000));
      send_item(make_item(FUNC_PAL_WRITE, 255, 24'hFFFFFF, 16'hFFFF));
      send_item(make_item(FUNC_PAL_WRITE, 128, 24'hA55AC3, 16'h5A5A));
      send_item(make_item(2'd3, 255, 24'hFFFFFF, 16'hFFFF));
      send_item(make_item(FUNC_DIRECT, 255, 24'hFFFFFF, 16'h0000));
      send_item(make_item(FUNC_DIRECT, 0, 24'h000000, 16'hFFFF));
   endtask

   task automatic test_every_format();
      logic [2:0] formats [6];
      formats = '{FMT_RGB565, FMT_BGR565, FMT_RGB555, FMT_RGBA5551, FMT_ARGB1555, FMT_UNUSED};
      for (int i = 0; i < 6; i++) begin
         set_mode(formats[i], (i % 2 == 1) ? 24'hFFFFFF : 24'h000000, i[0]);
         send_item(make_item(FUNC_INDEXED, 0, 24'h5A5A5A, 16'hA5A5));
         send_item(make_item(FUNC_INDEXED, 255, 24'hA5A5A5, 16'h5A5A));
         send_item(make_item(FUNC_INDEXED, 128, 24'hFFFFFF, 16'hFFFF));
      end
   endtask

   task automatic test_random_traffic();
      logic [2:0]       fmt;
      logic [RGB_W-1:0] bg;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         fmt = ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
         bg = (p == 0) ? 24'hFFFFFF : (p == 1) ? 24'h000000 : 24'($urandom_range(24'hFFFFFF));
         set_mode(fmt, bg, 1'($urandom_range(1)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 || $urandom_range(199) == 0) begin
               wait_for_results();
            end
            send_item(random_item());
         end
      end
   endtask

   task automatic test_back_to_back();
      set_mode(FMT_ARGB1555, 24'($urandom_range(24'hFFFFFF)), 1'b1);
      no_gaps = 1'b1;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         if (n == BURST_ITEMS / 2) begin
            set_mode(FMT_RGB565, 24'($urandom_range(24'hFFFFFF)), 1'b0);
         end
         send_item(random_item());
      end
      wait_for_results();
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_palette_load_and_direct();
      test_every_format();
      test_random_traffic();
      test_back_to_back();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (expected_texels.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
